/* hw/rtl/g2igc_pkg.sv */
// -----------------------------------------------------------------------------
// g2igc_pkg
// Shared types and constants for the GPS fix sentence to IGC B record block.
// -----------------------------------------------------------------------------
package g2igc_pkg;

  // Field sizes copied from the sentence (fields 1..5)
  localparam logic [3:0] TIME_DIGITS = 4'd6;
  localparam logic [3:0] LAT_DIGITS  = 4'd7;
  localparam logic [3:0] HEMI_DIGITS = 4'd1;
  localparam logic [3:0] LON_DIGITS  = 4'd8;

  // Sentence field numbers (1 = time)
  localparam logic [3:0] FLD_TIME    = 4'd1;
  localparam logic [3:0] FLD_LAT     = 4'd2;
  localparam logic [3:0] FLD_NS      = 4'd3;
  localparam logic [3:0] FLD_LON     = 4'd4;
  localparam logic [3:0] FLD_EW      = 4'd5;
  localparam logic [3:0] FLD_QUAL    = 4'd7;
  localparam logic [3:0] FLD_BARO    = 4'd8;
  localparam logic [3:0] FLD_ALT     = 4'd9;
  localparam logic [3:0] FLD_ALT_END = 4'd10;
  localparam logic [3:0] FLD_CRLF    = 4'd11;
  localparam logic [3:0] FLD_IDLE    = 4'd12;

  // digits_left value once the altitude dot has been seen
  localparam logic [3:0] DONE_MARK   = 4'd15;

  // Characters
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // Command codes
  localparam logic CMD_START = 1'b0;

  // Division by ten: q = (v * 52429) >> 19, exact for 16-bit v
  localparam logic [31:0] RECIP10  = 32'd52429;
  localparam int          RECIP_SH = 19;

  // What an accepted item asks for
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_START,
    ACT_COPY,
    ACT_A,
    ACT_ALT,
    ACT_CRLF,
    ACT_ALT_WR,
    ACT_DOT
  } act_t;

  // Source of the output byte
  typedef enum logic [2:0] {
    OSEL_CHAR,
    OSEL_A,
    OSEL_B,
    OSEL_CR,
    OSEL_LF,
    OSEL_ALT
  } osel_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_SHIFT,
    ST_PUT_B,
    ST_PUT_A,
    ST_PUT_CHAR,
    ST_PUT_CR,
    ST_PUT_LF,
    ST_PUT_ALT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic  accept;
    logic  conv_step;
    logic  shift_step;
    logic  rotate;
    logic  out_load;
    osel_t out_sel;
    logic  out_last;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    act_t       act;
    logic [3:0] digits_left;
    logic       out_free;
  } dp_status_t;

endpackage

/* hw/rtl/g2igc_ctrl.sv */
// -----------------------------------------------------------------------------
// g2igc_ctrl
// Sequencer: takes one item at a time, runs the digit conversion, the
// altitude realignment and the output byte sequences.
// -----------------------------------------------------------------------------
module g2igc_ctrl #(
  parameter int ALT_DIGITS = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  g2igc_pkg::dp_status_t  status_i,
  output g2igc_pkg::dp_cmd_t     cmd_o
);
  import g2igc_pkg::*;

  localparam logic [3:0] NDIG = 4'(ALT_DIGITS);

  state_t     state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       take;

  assign take = in_valid && (state_r == ST_IDLE);

  // State and step counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (status_i.act)
            ACT_START: state_nxt = ST_CONV;
            ACT_COPY:  state_nxt = ST_PUT_CHAR;
            ACT_A:     state_nxt = ST_PUT_A;
            ACT_ALT:   state_nxt = ST_PUT_ALT;
            ACT_CRLF:  state_nxt = ST_PUT_CR;
            ACT_DOT:   state_nxt = (status_i.digits_left == 4'd0) ? ST_IDLE : ST_SHIFT;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CONV:     if (cnt_r == 4'd1) state_nxt = ST_PUT_B;
      ST_SHIFT:    if (cnt_r == 4'd1) state_nxt = ST_IDLE;
      ST_PUT_B, ST_PUT_A, ST_PUT_CHAR, ST_PUT_LF: begin
        if (status_i.out_free) state_nxt = ST_IDLE;
      end
      ST_PUT_CR:   if (status_i.out_free) state_nxt = ST_PUT_LF;
      ST_PUT_ALT:  if (status_i.out_free && cnt_r == 4'd1) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Step counter
  always_comb begin
    cnt_nxt = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (status_i.act == ACT_DOT) cnt_nxt = status_i.digits_left;
          else                         cnt_nxt = NDIG;
        end
      end
      ST_CONV, ST_SHIFT: cnt_nxt = cnt_r - 4'd1;
      ST_PUT_ALT:        if (status_i.out_free) cnt_nxt = cnt_r - 4'd1;
      default:           cnt_nxt = cnt_r;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall         = (state_r != ST_IDLE);
    cmd_o            = '0;
    cmd_o.out_sel    = OSEL_CHAR;
    unique case (state_r)
      ST_IDLE:     cmd_o.accept     = in_valid;
      ST_CONV:     cmd_o.conv_step  = 1'b1;
      ST_SHIFT:    cmd_o.shift_step = 1'b1;
      ST_PUT_B: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.out_sel  = OSEL_B;
        cmd_o.out_last = 1'b1;
      end
      ST_PUT_A: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.out_sel  = OSEL_A;
        cmd_o.out_last = 1'b1;
      end
      ST_PUT_CHAR: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.out_sel  = OSEL_CHAR;
        cmd_o.out_last = 1'b1;
      end
      ST_PUT_CR: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.out_sel  = OSEL_CR;
      end
      ST_PUT_LF: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.out_sel  = OSEL_LF;
        cmd_o.out_last = 1'b1;
      end
      ST_PUT_ALT: begin
        cmd_o.out_load = status_i.out_free;
        cmd_o.rotate   = status_i.out_free;
        cmd_o.out_sel  = OSEL_ALT;
        cmd_o.out_last = (cnt_r == 4'd1);
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

/* hw/rtl/g2igc_dpath.sv */
// -----------------------------------------------------------------------------
// g2igc_dpath
// Field tracking, altitude digit register, divide-by-ten step and the
// output register.
// -----------------------------------------------------------------------------
module g2igc_dpath #(
  parameter int ALT_DIGITS = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_cmd,
  input  logic [7:0]             in_sentence_byte,
  input  logic signed [16:0]     in_baro_alt_m,
  output logic [7:0]             out_char,
  output logic                   out_last,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  g2igc_pkg::dp_cmd_t     cmd_i,
  output g2igc_pkg::dp_status_t  status_o
);
  import g2igc_pkg::*;

  localparam logic [3:0] NDIG = 4'(ALT_DIGITS);

  logic [3:0]  field_r, field_nxt;
  logic [3:0]  dl_r, dl_nxt;
  logic [7:0]  alt_r   [ALT_DIGITS];
  logic [7:0]  alt_nxt [ALT_DIGITS];
  logic [15:0] val_r, val_nxt;
  logic [7:0]  char_r;
  logic [7:0]  ochar_r, ochar_nxt;
  logic        olast_r, olast_nxt;
  logic        ovalid_r, ovalid_nxt;

  logic        is_comma;
  logic [3:0]  field_inc;
  act_t        act;
  logic [31:0] prod;
  logic [12:0] quot;
  logic [15:0] quot_x10;
  logic [15:0] rem;
  logic [7:0]  digit;

  // Item decode
  assign is_comma  = (in_sentence_byte == CH_COMMA);
  assign field_inc = (field_r < FLD_IDLE) ? field_r + 4'd1 : field_r;

  always_comb begin
    act = ACT_NONE;
    if (in_cmd == CMD_START) begin
      act = ACT_START;
    end else if (is_comma) begin
      case (field_inc)
        FLD_QUAL:                  act = ACT_A;
        FLD_BARO, FLD_ALT_END:     act = ACT_ALT;
        FLD_CRLF:                  act = ACT_CRLF;
        default:                   act = ACT_NONE;
      endcase
    end else if (field_r == FLD_ALT) begin
      if (dl_r <= NDIG) begin
        if (in_sentence_byte == CH_DOT) act = ACT_DOT;
        else if (dl_r != 4'd0)          act = ACT_ALT_WR;
      end
    end else if (field_r < FLD_BARO && in_sentence_byte != CH_DOT && dl_r != 4'd0) begin
      act = ACT_COPY;
    end
  end

  assign status_o.act         = act;
  assign status_o.digits_left = dl_r;
  assign status_o.out_free    = !ovalid_r || !out_stall;

  // Divide by ten, one digit per step
  assign prod     = {16'd0, val_r} * RECIP10;
  assign quot     = prod[31:RECIP_SH];
  assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem      = val_r - quot_x10;
  assign digit    = CH_ZERO + {4'd0, rem[3:0]};

  // Field number and characters left
  always_comb begin
    field_nxt = field_r;
    dl_nxt    = dl_r;
    if (cmd_i.accept) begin
      if (in_cmd == CMD_START) begin
        field_nxt = FLD_TIME;
        dl_nxt    = TIME_DIGITS;
      end else if (is_comma) begin
        field_nxt = field_inc;
        case (field_inc)
          FLD_LAT:               dl_nxt = LAT_DIGITS;
          FLD_NS, FLD_EW:        dl_nxt = HEMI_DIGITS;
          FLD_LON:               dl_nxt = LON_DIGITS;
          FLD_BARO, FLD_ALT_END: dl_nxt = 4'd0;
          FLD_ALT:               dl_nxt = NDIG;
          default:               dl_nxt = dl_r;
        endcase
      end else if (act == ACT_DOT) begin
        dl_nxt = DONE_MARK;
      end else if (act == ACT_ALT_WR || act == ACT_COPY) begin
        dl_nxt = dl_r - 4'd1;
      end
    end
  end

  // Altitude digit register: write, shift down, rotate up
  always_comb begin
    for (int k = 0; k < ALT_DIGITS; k++) alt_nxt[k] = alt_r[k];
    if (cmd_i.accept && act == ACT_ALT_WR) begin
      for (int k = 0; k < ALT_DIGITS; k++) begin
        if (4'(k) == dl_r - 4'd1) alt_nxt[k] = in_sentence_byte;
      end
    end else if (cmd_i.conv_step || cmd_i.shift_step) begin
      for (int k = 0; k < ALT_DIGITS - 1; k++) alt_nxt[k] = alt_r[k+1];
      alt_nxt[ALT_DIGITS-1] = cmd_i.conv_step ? digit : CH_ZERO;
    end else if (cmd_i.rotate) begin
      alt_nxt[0] = alt_r[ALT_DIGITS-1];
      for (int k = 1; k < ALT_DIGITS; k++) alt_nxt[k] = alt_r[k-1];
    end
  end

  // Value under conversion; negatives count as zero
  always_comb begin
    val_nxt = val_r;
    if (cmd_i.accept && in_cmd == CMD_START) begin
      val_nxt = in_baro_alt_m[16] ? 16'd0 : in_baro_alt_m[15:0];
    end else if (cmd_i.conv_step) begin
      val_nxt = {3'd0, quot};
    end
  end

  // Output register
  always_comb begin
    ochar_nxt  = ochar_r;
    olast_nxt  = olast_r;
    ovalid_nxt = ovalid_r && out_stall;
    if (cmd_i.out_load) begin
      ovalid_nxt = 1'b1;
      olast_nxt  = cmd_i.out_last;
      case (cmd_i.out_sel)
        OSEL_A:   ochar_nxt = CH_A;
        OSEL_B:   ochar_nxt = CH_B;
        OSEL_CR:  ochar_nxt = CH_CR;
        OSEL_LF:  ochar_nxt = CH_LF;
        OSEL_ALT: ochar_nxt = alt_r[ALT_DIGITS-1];
        default:  ochar_nxt = char_r;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r  <= FLD_IDLE;
      dl_r     <= 4'd0;
      ovalid_r <= 1'b0;
      for (int k = 0; k < ALT_DIGITS; k++) alt_r[k] <= CH_ZERO;
    end else begin
      field_r  <= field_nxt;
      dl_r     <= dl_nxt;
      ovalid_r <= ovalid_nxt;
      for (int k = 0; k < ALT_DIGITS; k++) alt_r[k] <= alt_nxt[k];
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
    if (cmd_i.accept) char_r <= in_sentence_byte;
  end

  assign out_char  = ochar_r;
  assign out_last  = olast_r;
  assign out_valid = ovalid_r;

endmodule

/* hw/rtl/gga_to_igc_b_record.sv */
// Copy byte: accepted into a byte register, then loaded into the output register.
// Start: ALT_DIGITS divide-by-ten steps, then 'B'.
// Altitude emission: one byte per cycle from the digit register while not stalled.
// Altitude dot: realignment shifts one place a cycle, one per digit left unfilled.
// Output stall holds the byte sequences; one item is worked on at a time.
// Reset (rst_n low, synchronous): idle until a start, digits read as '0'.
// -----------------------------------------------------------------------------
// gga_to_igc_b_record
// Builds an IGC B record from the bytes of a GPS fix sentence.
// -----------------------------------------------------------------------------
module gga_to_igc_b_record #(
  parameter int ALT_DIGITS = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic [7:0]         in_sentence_byte,
  input  logic signed [16:0] in_baro_alt_m,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_char,
  output logic               out_last
);
  import g2igc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  g2igc_ctrl #(
    .ALT_DIGITS (ALT_DIGITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status_i (status),
    .cmd_o    (cmd)
  );

  g2igc_dpath #(
    .ALT_DIGITS (ALT_DIGITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_cmd           (in_cmd),
    .in_sentence_byte (in_sentence_byte),
    .in_baro_alt_m    (in_baro_alt_m),
    .out_char         (out_char),
    .out_last         (out_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .cmd_i            (cmd),
    .status_o         (status)
  );

endmodule

/* verif/b_record_checker.sv */
// -----------------------------------------------------------------------------
// b_record_checker
// Watches both channels of the B record builder. Each accepted sentence item
// runs through a private model of the record state. The bytes it should give
// are queued, and each accepted output byte is compared with the oldest one.
// -----------------------------------------------------------------------------
module b_record_checker
  import g2igc_pkg::*;
#(
  parameter int ALT_N = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_cmd,
  input  logic [7:0]         in_sentence_byte,
  input  logic signed [16:0] in_baro_alt_m,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [7:0]         out_char,
  input  logic               out_last,
  output int unsigned        mismatches,
  output int unsigned        bytes_owed
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } rec_byte_t;

  // Model state: field being read, slots left, stored altitude digits
  logic [3:0] field_no;
  logic [3:0] slots_left;
  logic [7:0] alt_store [ALT_N];

  rec_byte_t record_q [$];
  rec_byte_t want;

  initial begin
    mismatches = 0;
    bytes_owed = 0;
  end

  task automatic clear_record();
    field_no   = FLD_IDLE;
    slots_left = '0;
    for (int i = 0; i < ALT_N; i++) alt_store[i] = CH_ZERO;
    record_q.delete();
  endtask

  // Advance the record by one accepted item and queue the bytes it gives
  task automatic step_record(input logic cmd, input logic [7:0] c,
                             input logic [16:0] baro);
    logic [7:0]  emitted [$];
    logic [16:0] v;
    if (cmd == CMD_START) begin
      // negative altitude clamps to zero; digits above ALT_N fall away
      v = baro[16] ? 17'd0 : baro;
      for (int i = 0; i < ALT_N; i++) begin
        alt_store[i] = CH_ZERO + 8'(v % 17'd10);
        v = v / 17'd10;
      end
      field_no   = FLD_TIME;
      slots_left = TIME_DIGITS;
      emitted.push_back(CH_B);
    end else if (c == CH_COMMA) begin
      if (field_no < FLD_IDLE) field_no = field_no + 4'd1;
      case (field_no)
        FLD_LAT: slots_left = LAT_DIGITS;
        FLD_NS, FLD_EW: slots_left = HEMI_DIGITS;
        FLD_LON: slots_left = LON_DIGITS;
        FLD_QUAL: emitted.push_back(CH_A);
        FLD_BARO, FLD_ALT_END: begin
          for (int i = ALT_N - 1; i >= 0; i--) emitted.push_back(alt_store[i]);
          slots_left = '0;
        end
        FLD_ALT: slots_left = 4'(ALT_N);
        FLD_CRLF: begin
          emitted.push_back(CH_CR);
          emitted.push_back(CH_LF);
        end
        default: ;
      endcase
    end else if (field_no == FLD_ALT) begin
      // GPS altitude: fill from the top, realign on the dot, then ignore
      if (int'(slots_left) <= ALT_N) begin
        if (c != CH_DOT) begin
          if (slots_left != 0) begin
            alt_store[int'(slots_left) - 1] = c;
            slots_left = slots_left - 4'd1;
          end
        end else begin
          for (int k = 0; k < ALT_N; k++) begin
            if (int'(slots_left) + k < ALT_N) alt_store[k] = alt_store[int'(slots_left) + k];
            else alt_store[k] = CH_ZERO;
          end
          slots_left = DONE_MARK;
        end
      end
    end else if (field_no < FLD_BARO && c != CH_DOT && slots_left != 0) begin
      slots_left = slots_left - 4'd1;
      emitted.push_back(c);
    end
    foreach (emitted[i]) record_q.push_back('{ch: emitted[i], last: i == emitted.size() - 1});
  endtask

  // Compare output transfers first, then model the input transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_record();
    end else begin
      if (out_valid && !out_stall) begin
        if (record_q.size() == 0) begin
          $error("out_char: expected none, got %h (out_last %b)", out_char, out_last);
          mismatches++;
        end else begin
          want = record_q.pop_front();
          if (out_char !== want.ch) begin
            $error("out_char: expected %h, got %h", want.ch, out_char);
            mismatches++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %b, got %b", want.last, out_last);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) step_record(in_cmd, in_sentence_byte, in_baro_alt_m);
    end
    bytes_owed = record_q.size();
  end

endmodule

/* verif/tb.sv */
// -----------------------------------------------------------------------------
// tb
// Drives GPS fix sentences into the B record builder. It starts with a few
// directed records, then sends mostly well-formed random sentences, some of
// them cut short or garbled, with noise items in between. The input side
// idles in bursts and the output side stalls on its own pattern.
// -----------------------------------------------------------------------------
module tb;
  import g2igc_pkg::*;

  localparam int ALT_N       = 5;
  localparam int ITEM_TARGET = 330;

  logic               clk              = 1'b0;
  logic               rst_n            = 1'b0;
  logic               in_valid         = 1'b0;
  logic               in_stall;
  logic               in_cmd           = 1'b1;
  logic [7:0]         in_sentence_byte = 8'h00;
  logic signed [16:0] in_baro_alt_m    = 17'sd0;
  logic               out_valid;
  logic               out_stall        = 1'b0;
  logic [7:0]         out_char;
  logic               out_last;

  int unsigned mismatches;
  int unsigned bytes_owed;

  int         burst_left = 0;
  int         n_sent     = 0;
  logic [7:0] line_q [$];

  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;

  always #5 clk = ~clk;

  gga_to_igc_b_record #(.ALT_DIGITS(ALT_N)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_sentence_byte (in_sentence_byte),
    .in_baro_alt_m    (in_baro_alt_m),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char         (out_char),
    .out_last         (out_last)
  );

  b_record_checker #(.ALT_N(ALT_N)) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_sentence_byte (in_sentence_byte),
    .in_baro_alt_m    (in_baro_alt_m),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char         (out_char),
    .out_last         (out_last),
    .mismatches       (mismatches),
    .bytes_owed       (bytes_owed)
  );

  // Output back-pressure: free, light, heavy or periodic, changing now and then
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_tick % 7) < 3);
    endcase
  end

  // One input transfer; called at a falling edge, returns at a falling edge
  task automatic send_item(input logic cmd, input logic [7:0] ch, input logic [16:0] baro);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    in_valid         <= 1'b1;
    in_cmd           <= cmd;
    in_sentence_byte <= ch;
    in_baro_alt_m    <= baro;
    burst_left--;
    n_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b1, 8'(s[i]), 17'($urandom));
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_item(1'b1, line_q[i], 17'($urandom));
  endtask

  // Hold off until every expected byte is out, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (bytes_owed != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  function automatic logic [16:0] pick_baro();
    case ($urandom_range(0, 3))
      0: return 17'($urandom_range(0, 9999));
      1: return 17'($urandom_range(0, 65535));
      2: return 17'h10000 | 17'($urandom_range(0, 65535));
      default: return 17'($urandom);
    endcase
  endfunction

  task automatic add_digits(input int n);
    repeat (n) line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic add_number(input int int_n, input int frac_max);
    add_digits(int_n);
    if ($urandom_range(0, 3) != 0) begin
      line_q.push_back(CH_DOT);
      add_digits($urandom_range(0, frac_max));
    end
    line_q.push_back(CH_COMMA);
  endtask

  task automatic add_hemi(input logic [7:0] a, input logic [7:0] b);
    case ($urandom_range(0, 5))
      0: ;
      1: begin
        line_q.push_back(a);
        line_q.push_back(b);
      end
      default: line_q.push_back($urandom_range(0, 1) ? a : b);
    endcase
    line_q.push_back(CH_COMMA);
  endtask

  // A fix sentence with random content, sometimes garbled or cut short
  task automatic build_sentence();
    int pos;
    line_q.delete();
    add_number($urandom_range(3, 8), 3);
    add_number($urandom_range(2, 6), 5);
    add_hemi("N", "S");
    add_number($urandom_range(3, 7), 5);
    add_hemi("E", "W");
    add_number($urandom_range(0, 2), 1);
    add_number($urandom_range(0, 3), 1);
    add_number($urandom_range(0, 2), 2);
    if ($urandom_range(0, 5) == 0) line_q.push_back("-");
    add_number($urandom_range(0, 8), 3);
    line_q.push_back("M");
    line_q.push_back(CH_COMMA);
    add_number($urandom_range(0, 3), 2);
    line_q.push_back("M");
    line_q.push_back(CH_COMMA);
    if ($urandom_range(0, 1)) begin
      line_q.push_back(CH_COMMA);
      line_q.push_back("*");
      add_digits(2);
    end
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        pos = $urandom_range(0, line_q.size() - 1);
        line_q[pos] = 8'($urandom_range(0, 255));
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      pos = $urandom_range(1, line_q.size());
      while (line_q.size() > pos) void'(line_q.pop_back());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Idle before any start: no bytes expected
    send_item(1'b1, CH_COMMA, 17'h00000);
    send_item(1'b1, "Z", 17'h1FFFF);

    // Altitude extremes, restarts back to back
    send_item(CMD_START, 8'hFF, 17'h18000);
    send_item(CMD_START, 8'h00, 17'h0FFFF);
    send_item(CMD_START, 8'hAA, 17'h1FFFF);
    send_item(CMD_START, 8'h55, 17'h00000);
    // Empty fields, stray byte with a hemisphere slot left, surplus altitude
    // digits with a fraction, extra commas once idle
    send_text(",.,,,,,Q,,1234567.89,,,,");
    // Altitude without a dot over stored baro digits
    send_item(CMD_START, 8'h00, 17'd407);
    send_text("9,,,,,,,,42,,,");
    drain();

    while (n_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 6))
          send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 17'($urandom));
      end else begin
        build_sentence();
        send_item(CMD_START, 8'($urandom_range(0, 255)), pick_baro());
        send_line();
      end
      if ($urandom_range(0, 5) == 0) drain();
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (bytes_owed != 0) @(negedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
